>>> hw/rtl/ptse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thick stroke extruder package
// Shared widths, command codes, control structs and helpers.
// ----------------------------------------------------------------------------
package ptse_pkg;

   localparam int MAX_VERTICES = 65536;
   localparam int VCOUNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 32;
   localparam int THICK_W      = 31;
   localparam int SLOT_W       = 16;
   localparam int MAG_W        = 31;
   localparam int DIFF_W       = COORD_W + 2;

   localparam logic [THICK_W-1:0] THICK_RESET = 31'd65536;

   // Sources of the vector handed to the normalizer.
   localparam logic [1:0] SRC_C_MINUS_B = 2'd0;
   localparam logic [1:0] SRC_A_MINUS_B = 2'd1;
   localparam logic [1:0] SRC_B_MINUS_C = 2'd2;
   localparam logic [1:0] SRC_BISECT    = 2'd3;

   // Offset scaling targets.
   localparam logic [2:0] SCL_NONE = 3'd0;
   localparam logic [2:0] SCL_OX   = 3'd1;
   localparam logic [2:0] SCL_OY   = 3'd2;
   localparam logic [2:0] SCL_PX   = 3'd3;
   localparam logic [2:0] SCL_PY   = 3'd4;

   // Result items in the order they leave the block.
   localparam logic [2:0] ITEM_V0  = 3'd0;
   localparam logic [2:0] ITEM_V1  = 3'd1;
   localparam logic [2:0] ITEM_V2  = 3'd2;
   localparam logic [2:0] ITEM_V3  = 3'd3;
   localparam logic [2:0] ITEM_T0  = 3'd4;
   localparam logic [2:0] ITEM_T1  = 3'd5;
   localparam logic [2:0] ITEM_OVF = 3'd6;

   typedef struct packed {
      logic              load_point;
      logic              commit;
      logic              norm_start;
      logic [1:0]        norm_src;
      logic              save_u;
      logic [2:0]        scale_sel;
      logic              clear_deg;
      logic              emit;
      logic [2:0]        item;
      logic              first_mode;
      logic [SLOT_W-1:0] slot_base;
   } ptse_cmd_type;

   typedef struct packed {
      logic norm_done;
      logic norm_idle;
      logic out_free;
   } ptse_stat_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[COORD_W] != v[COORD_W-1]) begin
         r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ptse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thick stroke extruder channels
// Point request, mesh result and thickness write channels.
// ----------------------------------------------------------------------------
interface ptse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ptse_pkg::COORD_W-1:0]  point_x;
   logic signed [ptse_pkg::COORD_W-1:0]  point_y;
   modport source(output valid, point_x, point_y, input ready);
   modport sink(input valid, point_x, point_y, output ready);
endinterface

interface ptse_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 item_kind;
   logic [ptse_pkg::SLOT_W-1:0]          vertex_slot;
   logic signed [ptse_pkg::COORD_W-1:0]  vertex_x;
   logic signed [ptse_pkg::COORD_W-1:0]  vertex_y;
   logic [ptse_pkg::SLOT_W-1:0]          tri_first;
   logic [ptse_pkg::SLOT_W-1:0]          tri_second;
   logic [ptse_pkg::SLOT_W-1:0]          tri_third;
   logic                                 degenerate;
   logic                                 last_of_run;
   modport source(output valid, item_kind, vertex_slot, vertex_x, vertex_y, tri_first,
                  tri_second, tri_third, degenerate, last_of_run, input ready);
   modport sink(input valid, item_kind, vertex_slot, vertex_x, vertex_y, tri_first,
                tri_second, tri_third, degenerate, last_of_run, output ready);
endinterface

interface ptse_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ptse_pkg::THICK_W-1:0]     line_thickness;
   modport source(output valid, line_thickness, input ready);
   modport sink(input valid, line_thickness, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ptse_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector normalizer
// Iterative unit vector: squares, bitwise square root, two parallel dividers.
// ----------------------------------------------------------------------------
module ptse_norm (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire signed [ptse_pkg::DIFF_W-1:0]   dx,
   input  wire signed [ptse_pkg::DIFF_W-1:0]   dy,
   output logic                                idle,
   output logic                                done,
   output logic                                zero,
   output logic signed [ptse_pkg::COORD_W-1:0] unit_x,
   output logic signed [ptse_pkg::COORD_W-1:0] unit_y
);

   localparam logic [2:0] N_IDLE = 3'd0;
   localparam logic [2:0] N_SQX  = 3'd1;
   localparam logic [2:0] N_SQY  = 3'd2;
   localparam logic [2:0] N_SQRT = 3'd3;
   localparam logic [2:0] N_DIV  = 3'd4;

   localparam int MW = ptse_pkg::MAG_W;
   localparam int DW = ptse_pkg::DIFF_W;

   logic [2:0]          state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [MW-1:0]       mx_ff, mx_in, my_ff, my_in;
   logic                sx_ff, sx_in, sy_ff, sy_in;
   logic [63:0]         acc_ff, acc_in;
   logic [33:0]         rem_ff, rem_in;
   logic [31:0]         root_ff, root_in;
   logic [32:0]         rx_ff, rx_in, ry_ff, ry_in;
   logic [30:0]         qx_ff, qx_in, qy_ff, qy_in;
   logic                first_ff, first_in;
   logic signed [31:0]  ux_ff, ux_in, uy_ff, uy_in;
   logic                zero_ff, zero_in, done_ff, done_in;

   logic [DW-1:0]       ax_mag, ay_mag;
   logic [MW-1:0]       mul_a;
   logic [2*MW-1:0]     prod;
   logic [35:0]         rem_t, trial;
   logic [32:0]         tx, ty, len33;
   logic                gex, gey;

   always_comb begin
      ax_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay_mag = dy[DW-1] ? DW'(-dy) : DW'(dy);
      mul_a  = (state_ff == N_SQX) ? mx_ff : my_ff;
      prod   = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_a};
      rem_t  = {rem_ff, acc_ff[63:62]};
      trial  = {2'b00, root_ff, 2'b01};
      len33  = {1'b0, root_ff};
      tx     = first_ff ? rx_ff : {rx_ff[31:0], 1'b0};
      ty     = first_ff ? ry_ff : {ry_ff[31:0], 1'b0};
      gex    = (tx >= len33);
      gey    = (ty >= len33);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      first_in = first_ff;
      ux_in    = ux_ff;
      uy_in    = uy_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               sx_in = dx[DW-1];
               sy_in = dy[DW-1];
               if (ax_mag == '0 && ay_mag == '0) begin
                  ux_in   = '0;
                  uy_in   = '0;
                  zero_in = 1'b1;
                  done_in = 1'b1;
               end else begin
                  zero_in = 1'b0;
                  // Large magnitudes are halved so the squares fit.
                  if (ax_mag[DW-1:MW] != '0 || ay_mag[DW-1:MW] != '0) begin
                     mx_in = ax_mag[MW:1];
                     my_in = ay_mag[MW:1];
                  end else begin
                     mx_in = ax_mag[MW-1:0];
                     my_in = ay_mag[MW-1:0];
                  end
                  state_in = N_SQX;
               end
            end
         end
         N_SQX: begin
            acc_in   = 64'(prod);
            state_in = N_SQY;
         end
         N_SQY: begin
            acc_in   = acc_ff + 64'(prod);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = 5'd31;
            state_in = N_SQRT;
         end
         N_SQRT: begin
            if (rem_t >= trial) begin
               rem_in  = 34'(rem_t - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_t[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            acc_in = {acc_ff[61:0], 2'b00};
            if (cnt_ff == '0) begin
               rx_in    = {2'b00, mx_ff};
               ry_in    = {2'b00, my_ff};
               qx_in    = '0;
               qy_in    = '0;
               first_in = 1'b1;
               cnt_in   = 5'd30;
               state_in = N_DIV;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         N_DIV: begin
            rx_in    = gex ? 33'(tx - len33) : tx;
            ry_in    = gey ? 33'(ty - len33) : ty;
            qx_in    = {qx_ff[29:0], gex};
            qy_in    = {qy_ff[29:0], gey};
            first_in = 1'b0;
            if (cnt_ff == '0) begin
               ux_in    = sx_ff ? -$signed({1'b0, qx_in}) : $signed({1'b0, qx_in});
               uy_in    = sy_ff ? -$signed({1'b0, qy_in}) : $signed({1'b0, qy_in});
               done_in  = 1'b1;
               state_in = N_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      first_ff <= first_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      zero_ff  <= zero_in;
   end

   assign idle   = (state_ff == N_IDLE);
   assign done   = done_ff;
   assign zero   = zero_ff;
   assign unit_x = ux_ff;
   assign unit_y = uy_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == N_IDLE)
      else $error("normalizer reported done while busy");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !zero_ff) |-> (ux_ff <= 32'sd1073741824 && ux_ff >= -32'sd1073741824
                                 && uy_ff <= 32'sd1073741824 && uy_ff >= -32'sd1073741824))
      else $error("unit vector component exceeds one");

endmodule
`default_nettype wire

>>> hw/rtl/ptse_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thick stroke extruder datapath
// Point history, normalizer, offset scaling and the result register.
// ----------------------------------------------------------------------------
module ptse_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  ptse_pkg::ptse_cmd_type              cmd,
   output ptse_pkg::ptse_stat_type             stat,
   input  wire                                 csr_write,
   input  wire [ptse_pkg::THICK_W-1:0]         csr_data,
   input  wire signed [ptse_pkg::COORD_W-1:0]  in_x,
   input  wire signed [ptse_pkg::COORD_W-1:0]  in_y,
   input  wire                                 out_ready,
   output logic                                out_valid,
   output logic                                out_kind,
   output logic [ptse_pkg::SLOT_W-1:0]         out_slot,
   output logic signed [ptse_pkg::COORD_W-1:0] out_x,
   output logic signed [ptse_pkg::COORD_W-1:0] out_y,
   output logic [ptse_pkg::SLOT_W-1:0]         out_t0,
   output logic [ptse_pkg::SLOT_W-1:0]         out_t1,
   output logic [ptse_pkg::SLOT_W-1:0]         out_t2,
   output logic                                out_deg,
   output logic                                out_last
);

   localparam int CW = ptse_pkg::COORD_W;
   localparam int DW = ptse_pkg::DIFF_W;
   localparam int SW = ptse_pkg::SLOT_W;
   localparam int TW = ptse_pkg::THICK_W;

   logic [TW-1:0]         thick_ff;
   logic signed [CW-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [CW-1:0]  usx_ff, usy_ff, ox_ff, oy_ff, px_ff, py_ff;
   logic                  deg_ff;
   logic                  ov_ff;
   logic                  ok_ff, ok_in;
   logic [SW-1:0]         os_ff, os_in, o0_ff, o0_in, o1_ff, o1_in, o2_ff, o2_in;
   logic signed [CW-1:0]  oxv_ff, oxv_in, oyv_ff, oyv_in;
   logic                  od_ff, od_in, ol_ff, ol_in;

   logic signed [DW-1:0]  ndx, ndy;
   logic                  n_idle, n_done, n_zero;
   logic signed [CW-1:0]  n_ux, n_uy;

   logic signed [CW:0]    sc_c;
   logic [CW:0]           sc_mag;
   logic [2*TW-1:0]       sc_prod;
   logic signed [CW-1:0]  sc_off;

   logic signed [CW-1:0]  v_pt_x, v_pt_y, v_off_x, v_off_y;
   logic                  v_sub;
   logic signed [CW:0]    v_sum_x, v_sum_y;
   logic [SW-1:0]         n;

   ptse_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.norm_start),
      .dx     (ndx),
      .dy     (ndy),
      .idle   (n_idle),
      .done   (n_done),
      .zero   (n_zero),
      .unit_x (n_ux),
      .unit_y (n_uy)
   );

   always_comb begin
      case (cmd.norm_src)
         ptse_pkg::SRC_C_MINUS_B: begin
            ndx = DW'(cx_ff) - DW'(bx_ff);
            ndy = DW'(cy_ff) - DW'(by_ff);
         end
         ptse_pkg::SRC_A_MINUS_B: begin
            ndx = DW'(ax_ff) - DW'(bx_ff);
            ndy = DW'(ay_ff) - DW'(by_ff);
         end
         ptse_pkg::SRC_B_MINUS_C: begin
            ndx = DW'(bx_ff) - DW'(cx_ff);
            ndy = DW'(by_ff) - DW'(cy_ff);
         end
         default: begin
            // Sum of the two segment normals (-uy, ux) and (-vy, vx).
            ndx = -DW'(usy_ff) - DW'(n_uy);
            ndy = DW'(usx_ff) + DW'(n_ux);
         end
      endcase
   end

   // Offset = |c| * thickness / 2^31 with the sign of c.
   always_comb begin
      case (cmd.scale_sel)
         ptse_pkg::SCL_OX: sc_c = -(CW+1)'(n_uy);
         ptse_pkg::SCL_OY: sc_c = (CW+1)'(n_ux);
         ptse_pkg::SCL_PX: sc_c = (CW+1)'(n_ux);
         ptse_pkg::SCL_PY: sc_c = (CW+1)'(n_uy);
         default:          sc_c = '0;
      endcase
      sc_mag  = sc_c[CW] ? (CW+1)'(-sc_c) : (CW+1)'(sc_c);
      sc_prod = {{TW{1'b0}}, sc_mag[TW-1:0]} * {{TW{1'b0}}, thick_ff};
      sc_off  = sc_c[CW] ? -$signed({1'b0, sc_prod[2*TW-1:TW]})
                         : $signed({1'b0, sc_prod[2*TW-1:TW]});
   end

   always_comb begin
      n = cmd.slot_base;
      v_pt_x  = bx_ff;
      v_pt_y  = by_ff;
      v_off_x = ox_ff;
      v_off_y = oy_ff;
      v_sub   = 1'b0;
      ok_in = 1'b0;
      os_in = '0;
      o0_in = '0;
      o1_in = '0;
      o2_in = '0;
      case (cmd.item)
         ptse_pkg::ITEM_V0: begin
            os_in = n;
            if (!cmd.first_mode) begin
               v_pt_x = cx_ff;
               v_pt_y = cy_ff;
            end
         end
         ptse_pkg::ITEM_V1: begin
            os_in = n + SW'(1);
            v_sub = 1'b1;
            if (!cmd.first_mode) begin
               v_pt_x = cx_ff;
               v_pt_y = cy_ff;
            end
         end
         ptse_pkg::ITEM_V2: begin
            if (cmd.first_mode) begin
               os_in  = n + SW'(2);
               v_pt_x = cx_ff;
               v_pt_y = cy_ff;
               v_sub  = 1'b1;
            end else begin
               os_in   = n - SW'(2);
               v_off_x = px_ff;
               v_off_y = py_ff;
            end
         end
         ptse_pkg::ITEM_V3: begin
            if (cmd.first_mode) begin
               os_in  = n + SW'(3);
               v_pt_x = cx_ff;
               v_pt_y = cy_ff;
            end else begin
               os_in   = n - SW'(1);
               v_off_x = px_ff;
               v_off_y = py_ff;
               v_sub   = 1'b1;
            end
         end
         ptse_pkg::ITEM_T0: begin
            ok_in = 1'b1;
            if (cmd.first_mode) begin
               o0_in = n;
               o1_in = n + SW'(1);
               o2_in = n + SW'(2);
            end else begin
               o0_in = n - SW'(2);
               o1_in = n - SW'(1);
               o2_in = n;
            end
         end
         ptse_pkg::ITEM_T1: begin
            ok_in = 1'b1;
            if (cmd.first_mode) begin
               o0_in = n + SW'(3);
               o1_in = n + SW'(1);
               o2_in = n + SW'(2);
            end else begin
               o0_in = n;
               o1_in = n - SW'(1);
               o2_in = n + SW'(1);
            end
         end
         default: begin
            ok_in = 1'b1;
         end
      endcase
      v_sum_x = v_sub ? (CW+1)'(v_pt_x) - (CW+1)'(v_off_x) : (CW+1)'(v_pt_x) + (CW+1)'(v_off_x);
      v_sum_y = v_sub ? (CW+1)'(v_pt_y) - (CW+1)'(v_off_y) : (CW+1)'(v_pt_y) + (CW+1)'(v_off_y);
      oxv_in = ok_in ? '0 : ptse_pkg::sat_coord(v_sum_x);
      oyv_in = ok_in ? '0 : ptse_pkg::sat_coord(v_sum_y);
      od_in  = (cmd.item == ptse_pkg::ITEM_OVF) ? 1'b1 : deg_ff;
      ol_in  = (cmd.item == ptse_pkg::ITEM_OVF) || (cmd.item == ptse_pkg::ITEM_T1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= ptse_pkg::THICK_RESET;
         ax_ff    <= '0;
         ay_ff    <= '0;
         bx_ff    <= '0;
         by_ff    <= '0;
         ov_ff    <= 1'b0;
         deg_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            thick_ff <= csr_data;
         end
         if (cmd.commit) begin
            ax_ff <= bx_ff;
            ay_ff <= by_ff;
            bx_ff <= cx_ff;
            by_ff <= cy_ff;
         end
         if (cmd.clear_deg) begin
            deg_ff <= 1'b0;
         end else if (n_done && n_zero) begin
            deg_ff <= 1'b1;
         end
         if (cmd.emit) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         cx_ff <= in_x;
         cy_ff <= in_y;
      end
      if (cmd.save_u) begin
         usx_ff <= n_ux;
         usy_ff <= n_uy;
      end
      case (cmd.scale_sel)
         ptse_pkg::SCL_OX: ox_ff <= sc_off;
         ptse_pkg::SCL_OY: oy_ff <= sc_off;
         ptse_pkg::SCL_PX: px_ff <= sc_off;
         ptse_pkg::SCL_PY: py_ff <= sc_off;
         default: begin
         end
      endcase
      if (cmd.emit) begin
         ok_ff  <= ok_in;
         os_ff  <= ok_in ? '0 : os_in;
         oxv_ff <= oxv_in;
         oyv_ff <= oyv_in;
         o0_ff  <= o0_in;
         o1_ff  <= o1_in;
         o2_ff  <= o2_in;
         od_ff  <= od_in;
         ol_ff  <= ol_in;
      end
   end

   assign stat.norm_done = n_done;
   assign stat.norm_idle = n_idle;
   assign stat.out_free  = !ov_ff || out_ready;

   assign out_valid = ov_ff;
   assign out_kind  = ok_ff;
   assign out_slot  = os_ff;
   assign out_x     = oxv_ff;
   assign out_y     = oyv_ff;
   assign out_t0    = o0_ff;
   assign out_t1    = o1_ff;
   assign out_t2    = o2_ff;
   assign out_deg   = od_ff;
   assign out_last  = ol_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ptse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thick stroke extruder controller
// Sequences normalizations, offset scaling, result beats and state update.
// ----------------------------------------------------------------------------
module ptse_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  ptse_pkg::ptse_stat_type  stat,
   output ptse_pkg::ptse_cmd_type   cmd
);

   localparam int VW = ptse_pkg::VCOUNT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_WAIT_A = 4'd2;
   localparam logic [3:0] S_WAIT_B = 4'd3;
   localparam logic [3:0] S_OX     = 4'd4;
   localparam logic [3:0] S_OY     = 4'd5;
   localparam logic [3:0] S_WAIT_C = 4'd6;
   localparam logic [3:0] S_PX     = 4'd7;
   localparam logic [3:0] S_PY     = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;
   localparam logic [3:0] S_COMMIT = 4'd10;
   localparam logic [3:0] S_OVF    = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    seen_ff, seen_in;
   logic [VW-1:0] vcount_ff, vcount_in;
   logic [2:0]    k_ff, k_in;
   logic          first_ff, first_in;
   logic [VW:0]   need;
   logic          overflow;

   always_comb begin
      need     = (seen_ff == 2'd1) ? (VW+1)'(4) : (VW+1)'(2);
      overflow = ({1'b0, vcount_ff} + need) > (VW+1)'(ptse_pkg::MAX_VERTICES);
   end

   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      vcount_in = vcount_ff;
      k_in      = k_ff;
      first_in  = first_ff;
      req_ready = 1'b0;
      cmd            = '0;
      cmd.norm_src   = ptse_pkg::SRC_C_MINUS_B;
      cmd.scale_sel  = ptse_pkg::SCL_NONE;
      cmd.item       = k_ff;
      cmd.first_mode = first_ff;
      cmd.slot_base  = ptse_pkg::SLOT_W'(vcount_ff);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_point = 1'b1;
               state_in       = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (seen_ff == 2'd0) begin
               cmd.commit = 1'b1;
               seen_in    = 2'd1;
               state_in   = S_IDLE;
            end else if (overflow) begin
               state_in = S_OVF;
            end else begin
               first_in       = (seen_ff == 2'd1);
               cmd.norm_start = 1'b1;
               cmd.clear_deg  = 1'b1;
               cmd.norm_src   = (seen_ff == 2'd1) ? ptse_pkg::SRC_C_MINUS_B
                                                  : ptse_pkg::SRC_A_MINUS_B;
               state_in       = S_WAIT_A;
            end
         end
         S_WAIT_A: begin
            if (stat.norm_done) begin
               if (first_ff) begin
                  state_in = S_OX;
               end else begin
                  cmd.save_u     = 1'b1;
                  cmd.norm_start = 1'b1;
                  cmd.norm_src   = ptse_pkg::SRC_B_MINUS_C;
                  state_in       = S_WAIT_B;
               end
            end
         end
         S_WAIT_B: begin
            if (stat.norm_done) begin
               state_in = S_OX;
            end
         end
         S_OX: begin
            cmd.scale_sel = ptse_pkg::SCL_OX;
            state_in      = S_OY;
         end
         S_OY: begin
            cmd.scale_sel = ptse_pkg::SCL_OY;
            k_in          = ptse_pkg::ITEM_V0;
            if (first_ff) begin
               state_in = S_EMIT;
            end else begin
               cmd.norm_start = 1'b1;
               cmd.norm_src   = ptse_pkg::SRC_BISECT;
               state_in       = S_WAIT_C;
            end
         end
         S_WAIT_C: begin
            if (stat.norm_done) begin
               state_in = S_PX;
            end
         end
         S_PX: begin
            cmd.scale_sel = ptse_pkg::SCL_PX;
            state_in      = S_PY;
         end
         S_PY: begin
            cmd.scale_sel = ptse_pkg::SCL_PY;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            // The beat counter doubles as the item code.
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (k_ff == ptse_pkg::ITEM_T1) begin
                  state_in = S_COMMIT;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            vcount_in  = VW'({1'b0, vcount_ff} + need);
            seen_in    = 2'd2;
            state_in   = S_IDLE;
         end
         S_OVF: begin
            cmd.item = ptse_pkg::ITEM_OVF;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         seen_ff   <= 2'd0;
         vcount_ff <= '0;
         k_ff      <= '0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         vcount_ff <= vcount_in;
         k_ff      <= k_in;
         first_ff  <= first_in;
      end
   end

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3)
      else $error("point counter passed two");

   a_vcount_cap: assert property (@(posedge clock) disable iff (reset)
      {1'b0, vcount_ff} <= (VW+1)'(ptse_pkg::MAX_VERTICES))
      else $error("vertex count exceeds store size");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.norm_start |-> stat.norm_idle)
      else $error("normalizer started while busy");

endmodule
`default_nettype wire

>>> hw/rtl/polyline_thick_stroke_extruder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polyline thick stroke extruder
// Turns a stream of polyline points into a thick-line triangle mesh.
// ----------------------------------------------------------------------------
// One point is taken at a time; req_chan.ready is high only while the block
// is between points. The first point gives no result. The second point
// gives six result beats, and so does every later point. The shared
// normalizer works each vector by squaring, a 32-step square root and a
// 31-step division, run once for the second point and three times for
// each later one. A point that would overflow the vertex store gives one
// flagged beat and leaves the state unchanged. The final beat of a point
// waits in an output register, so a stall on it does not hold off the
// next point. Thickness writes on csr_chan are always accepted.
module polyline_thick_stroke_extruder (
   input  wire          clock,
   input  wire          reset,
   ptse_req_if.sink     req_chan,
   ptse_rsp_if.source   rsp_chan,
   ptse_csr_if.sink     csr_chan
);

   ptse_pkg::ptse_cmd_type  cmd;
   ptse_pkg::ptse_stat_type stat;
   logic                    req_ready;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   ptse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptse_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_write (csr_chan.valid),
      .csr_data  (csr_chan.line_thickness),
      .in_x      (req_chan.point_x),
      .in_y      (req_chan.point_y),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_kind  (rsp_chan.item_kind),
      .out_slot  (rsp_chan.vertex_slot),
      .out_x     (rsp_chan.vertex_x),
      .out_y     (rsp_chan.vertex_y),
      .out_t0    (rsp_chan.tri_first),
      .out_t1    (rsp_chan.tri_second),
      .out_t2    (rsp_chan.tri_third),
      .out_deg   (rsp_chan.degenerate),
      .out_last  (rsp_chan.last_of_run)
   );

endmodule
`default_nettype wire
